// ----- hdl/mi_pkg.sv -----
package mi_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_DONE
  } state_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Commands from the top level to the Euclid core.
  typedef struct packed {
    logic start;
    logic take;
  } core_cmd_t;

  // Status from the Euclid core to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic err;
  } core_sts_t;

endpackage

// ----- hdl/mi_if.sv -----
interface mi_in_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface mi_out_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             status;

  modport source (output valid, output inverse, output status, input ready);
  modport sink (input valid, input inverse, input status, output ready);
endinterface

interface mi_cfg_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

// ----- hdl/mi_euclid.sv -----
module mi_euclid #(
  parameter int WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mi_pkg::core_cmd_t cmd,
  input  logic [WIDTH-1:0]  value,
  input  logic [WIDTH-1:0]  modulus,
  output mi_pkg::core_sts_t sts,
  output logic [WIDTH-1:0]  inverse
);
  import mi_pkg::*;

  localparam int TW = WIDTH + 2;
  localparam int KW = $clog2(WIDTH);

  state_t state, state_next;

  logic [WIDTH-1:0]        m_q;
  logic [WIDTH-1:0]        r0, r1, d;
  logic signed [TW-1:0]    t0, t1, e;
  logic [KW-1:0]           k;

  logic                    shift_ok;
  logic                    ge;
  logic [WIDTH-1:0]        r0_sub;
  logic signed [TW-1:0]    t0_sub;
  logic signed [TW-1:0]    inv_full;
  logic                    err;

  // The divisor copy d is shifted up until it is aligned under r0, then one
  // quotient bit is produced per cycle while it shifts back down.
  assign shift_ok = (d[WIDTH-1] == 1'b0) && ({d[WIDTH-2:0], 1'b0} <= r0);
  assign ge       = (r0 >= d);
  assign r0_sub   = ge ? (r0 - d) : r0;
  assign t0_sub   = ge ? (t0 - e) : t0;

  assign inv_full = t0 + $signed({2'b00, m_q});
  assign err      = (m_q < WIDTH'(2)) || (r0 != WIDTH'(1));
  assign inverse  = err ? '0 : (t0[TW-1] ? inv_full[WIDTH-1:0] : t0[WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sts.idle   = (state == ST_IDLE);
    sts.done   = (state == ST_DONE);
    sts.err    = err;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = (value == '0) ? ST_DONE : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (!shift_ok) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (k == '0) begin
          state_next = (r0_sub == '0) ? ST_DONE : ST_ALIGN;
        end
      end
      ST_DONE: begin
        if (cmd.take) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          m_q <= modulus;
          r0  <= modulus;
          r1  <= value;
          t0  <= '0;
          t1  <= TW'(1);
          d   <= value;
          e   <= TW'(1);
          k   <= '0;
        end
      end
      ST_ALIGN: begin
        if (shift_ok) begin
          d <= {d[WIDTH-2:0], 1'b0};
          e <= e <<< 1;
          k <= k + KW'(1);
        end
      end
      ST_REDUCE: begin
        if (k == '0) begin
          // Quotient complete: the pair moves down one place.
          r0 <= r1;
          r1 <= r0_sub;
          t0 <= t1;
          t1 <= t0_sub;
          d  <= r0_sub;
          e  <= t0_sub;
        end else begin
          r0 <= r0_sub;
          t0 <= t0_sub;
          d  <= d >> 1;
          e  <= e >>> 1;
          k  <= k - KW'(1);
        end
      end
      ST_DONE: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALIGN || state == ST_REDUCE) |-> (d != '0))
    else $error("divisor is zero during a quotient step");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALIGN || state == ST_REDUCE) |-> (k <= KW'(WIDTH - 1)))
    else $error("alignment count out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !cmd.take) |=> (state == ST_DONE))
    else $error("result dropped before transfer");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == ST_IDLE))
    else $error("start issued while busy");
`endif

endmodule

// ----- hdl/modular_inverse_unit.sv -----
// Each Euclid quotient step shifts the divisor up into alignment, then reduces
// one quotient bit at a time back down; a zero value goes straight to done.
// Throughput: one item at a time; the next operand is taken once the core is idle again,
// when the last result is registered; that result waits in the output register meanwhile.
// Reset (synchronous, active high) sets modulus to 2 and clears all valid flags.
module modular_inverse_unit #(
  parameter int WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  mi_in_if.sink    operand,
  mi_out_if.source result,
  mi_cfg_if.sink   cfg
);
  import mi_pkg::*;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] core_inverse;
  logic             out_valid;
  logic [WIDTH-1:0] out_inverse;
  logic             out_status;
  core_cmd_t        cmd;
  core_sts_t        sts;

  assign cfg.ready     = 1'b1;
  assign operand.ready = sts.idle;

  assign cmd.start = operand.valid && sts.idle;
  assign cmd.take  = sts.done && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(2);
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  mi_euclid #(.WIDTH(WIDTH)) u_euclid (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .value   (operand.value),
    .modulus (modulus),
    .sts     (sts),
    .inverse (core_inverse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_inverse <= core_inverse;
      out_status  <= sts.err ? STATUS_ERR : STATUS_OK;
    end
  end

  assign result.valid   = out_valid;
  assign result.inverse = out_inverse;
  assign result.status  = out_status;

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mi_pkg::*;

  localparam int W            = 16;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 95;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic         status;
  } pending_inverse_t;

  class inverse_scoreboard;
    pending_inverse_t expected_inverses[$];
    int errors;
    int found;
    int refused;

    // Extended Euclid on (modulus, value mod modulus) with a signed Bezout coefficient.
    function pending_inverse_t predict_inverse(logic [W-1:0] v, logic [W-1:0] m);
      longint unsigned r0, r1, r2, q;
      longint t0, t1, t2;
      pending_inverse_t p;
      p.value   = v;
      p.modulus = m;
      p.inverse = '0;
      p.status  = STATUS_ERR;
      if (m < 2) return p;
      r0 = m;
      r1 = v % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q  = r0 / r1;
        r2 = r0 % r1;
        t2 = t0 - longint'(q) * t1;
        r0 = r1;
        r1 = r2;
        t0 = t1;
        t1 = t2;
      end
      if (r0 != 1) return p;
      p.status  = STATUS_OK;
      p.inverse = (t0 < 0) ? W'(longint'(m) + t0) : W'(t0);
      return p;
    endfunction

    function void note_operand(logic [W-1:0] v, logic [W-1:0] m);
      expected_inverses = {expected_inverses, predict_inverse(v, m)};
    endfunction

    function int pending();
      return expected_inverses.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [W-1:0] inverse, logic status);
      pending_inverse_t p;
      if (expected_inverses.size() == 0) begin
        report_mismatch($sformatf("result inverse=%0d status=%0b with nothing outstanding",
                                  inverse, status));
      end else begin
        p = expected_inverses.pop_front();
        if (p.status == STATUS_OK) found++;
        else refused++;
        if (inverse !== p.inverse)
          report_mismatch($sformatf("value=%0d mod %0d: inverse %0d, expected %0d",
                                    p.value, p.modulus, inverse, p.inverse));
        if (status !== p.status)
          report_mismatch($sformatf("value=%0d mod %0d: status %0b, expected %0b",
                                    p.value, p.modulus, status, p.status));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  mi_in_if  #(.WIDTH(W)) operand_ch ();
  mi_out_if #(.WIDTH(W)) result_ch ();
  mi_cfg_if #(.WIDTH(W)) cfg_ch ();

  modular_inverse_unit #(.WIDTH(W)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  inverse_scoreboard sb = new();

  logic [W-1:0] cur_modulus;
  int           src_idle_pct;
  int           sink_stall_pct;
  bit           sink_hold;
  int           operands_sent;
  int           modulus_writes;
  int           idle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (sink_hold) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.inverse, result_ch.status);
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_operand(input logic [W-1:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(negedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.value <= v;
    do @(posedge clk); while (!operand_ch.ready);
    sb.note_operand(v, cur_modulus);
    operands_sent++;
    @(negedge clk);
  endtask

  task automatic send_list(input logic [W-1:0] vals[$]);
    foreach (vals[i]) send_operand(vals[i]);
  endtask

  task automatic wait_drained();
    operand_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_modulus = m;
    modulus_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic hold_sink(input int cycles);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold = 1'b0;
  endtask

  // Mostly reduced, nonzero operands; the rest are raw words, zero and multiples
  // of the modulus.
  function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (m < 2 || (sel >= 70 && sel < 85)) return W'($urandom_range(0, 65535));
    if (sel < 70) return W'($urandom_range(1, m - 1));
    if (sel < 92) return '0;
    return W'(m * $urandom_range(1, 65535 / m));
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_operand(pick_value(cur_modulus));
  endtask

  initial begin
    logic [W-1:0] dir_vals[$];
    logic [W-1:0] mod_list[RAND_PHASES];

    rst              = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.modulus   = '0;
    result_ch.ready  = 1'b0;
    cur_modulus      = 16'd2;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    sink_hold        = 1'b0;
    operands_sent    = 0;
    modulus_writes   = 0;
    idle_count       = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reset modulus of two is used before any write.
    dir_vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF};
    send_list(dir_vals);
    wait_drained();

    write_modulus(16'd65521);
    dir_vals = '{16'd1, 16'd65520, 16'd65521, 16'hFFFF, 16'd2, 16'd12345};
    send_list(dir_vals);
    wait_drained();

    // Largest modulus: 3*5*17*257, so small factors give no inverse.
    write_modulus(16'hFFFF);
    dir_vals = '{16'd0, 16'd3, 16'd2, 16'hFFFE, 16'd256, 16'h8000};
    send_list(dir_vals);
    wait_drained();

    write_modulus(16'd256);
    dir_vals = '{16'h80, 16'hFF};
    send_list(dir_vals);
    wait_drained();

    // Moduli below two never yield an inverse.
    write_modulus(16'd0);
    dir_vals = '{16'd5, 16'd0};
    send_list(dir_vals);
    wait_drained();
    write_modulus(16'd1);
    dir_vals = '{16'd1, 16'd0};
    send_list(dir_vals);
    wait_drained();

    mod_list = '{16'd65521, 16'd2, 16'hFFFF, 16'd3, 16'd256, 16'd40000,
                 W'($urandom_range(2, 65535)), W'($urandom_range(2, 65535)),
                 16'd65521, W'($urandom_range(2, 1000)), W'($urandom_range(2, 65535)),
                 16'hFFFF};

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_modulus(mod_list[p]);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 53;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 53;
        end
        default: begin
          src_idle_pct   = 36;
          sink_stall_pct = 36;
        end
      endcase
      if (p == 4) begin
        // The result side stays closed while operands keep coming, so the
        // unit fills up and refuses its input.
        fork
          hold_sink(HOLD_CYCLES);
          run_random(PHASE_ITEMS);
        join
      end else if (p == 6) begin
        run_random(PHASE_ITEMS / 2);
        wait_drained();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Sent %0d operands under %0d modulus writes with all four idle patterns.",
             operands_sent, modulus_writes);
    $display("Inverses found: %0d, operands without inverse: %0d, mismatches: %0d.",
             sb.found, sb.refused, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/mi_pkg.sv
hdl/mi_if.sv
hdl/mi_euclid.sv
hdl/modular_inverse_unit.sv
sim/tb.sv
